// ----- src/rau_pkg.sv -----
// Package: item types, command and status codes for the rational arithmetic unit.
`default_nettype none
package rau_pkg;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_SAT      = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	// Clamp limits on the 65-bit zero-extended numerator magnitude
	localparam logic [64:0] NEG_LIMIT = 65'h0_8000_0000_0000_0000;
	localparam logic [64:0] POS_LIMIT = 65'h0_7FFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] num_a;
		logic signed [31:0] den_a;
		logic signed [31:0] num_b;
		logic signed [31:0] den_b;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] num_out;
		logic [62:0]        den_out;
		status_t            status;
	} out_item_t;

endpackage
`default_nettype wire

// ----- src/rational_arithmetic_unit_core.sv -----
// Top level: rational add/sub/mul/div with binary GCD reduction, one shared datapath.
//
// Input channel in_valid/in_stall/in_data carries a command and two fractions
// num_a/den_a and num_b/den_b. Output channel out_valid/out_stall/out_data carries
// the reduced numerator, a positive denominator and a status code.
// An item is taken when valid is high and stall is low.
// Each item runs through a small sequencer around one shared multiplier, one adder,
// a GCD subtract/compare step and a restoring division step: two multiplies (three
// for add and subtract, followed by one add), a zero check, a binary GCD loop, then
// two restoring divisions of 2*OPERAND_WIDTH bits that divide both terms by the GCD.
// Items with a zero denominator or a zero divisor go from acceptance straight to
// the final state; a zero numerator goes there from the zero check.
// in_stall is high from acceptance until the result is moved into the output
// register; one finished result may wait there while the next item is worked on.
// If out_stall holds, the output item stays stable and the next finished
// result waits in the sequencer.
// Asynchronous reset clears the sequencer and the output valid.
`default_nettype none
module rational_arithmetic_unit_core #(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire rau_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output rau_pkg::out_item_t      out_data
);

	localparam int W  = OPERAND_WIDTH;
	localparam int PW = 2 * W;
	localparam int CW = $clog2(PW);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_ADD, S_ZCHK, S_GCD, S_DIVN, S_DIVD, S_FIN
	} state_t;

	state_t               state_q;
	rau_pkg::cmd_t        cmd_q;
	logic [W-1:0]         na_q, da_q, nb_q, db_q;
	logic                 na_neg_q, da_neg_q, nb_neg_q, db_neg_q;
	logic [PW-1:0]        rn_q, rd_q, t2_q;
	logic                 rn_neg_q, rd_neg_q, t2_neg_q;
	logic [PW-1:0]        ga_q, gb_q, g_q;
	logic [CW-1:0]        k_q, cnt_q;
	logic [PW-1:0]        quo_q, rem_q, nmag_q;
	logic                 err_q, zero_q;
	rau_pkg::out_item_t   out_q;
	logic                 out_valid_q;

	// Operand extraction: low W bits, sign and magnitude
	logic [W-1:0] xa_n, xa_d, xb_n, xb_d;
	logic [W-1:0] ma_n, ma_d, mb_n, mb_d;
	logic         in_err;

	always_comb begin
		xa_n = in_data.num_a[W-1:0];
		xa_d = in_data.den_a[W-1:0];
		xb_n = in_data.num_b[W-1:0];
		xb_d = in_data.den_b[W-1:0];
		ma_n = xa_n[W-1] ? (~xa_n + 1'b1) : xa_n;
		ma_d = xa_d[W-1] ? (~xa_d + 1'b1) : xa_d;
		mb_n = xb_n[W-1] ? (~xb_n + 1'b1) : xb_n;
		mb_d = xb_d[W-1] ? (~xb_d + 1'b1) : xb_d;
		in_err = (ma_d == '0) || (mb_d == '0) ||
			((in_data.command == rau_pkg::CMD_DIV) && (mb_n == '0));
	end

	// Shared multiplier operand select
	logic [W-1:0]  mul_x, mul_y;
	logic          mul_sx, mul_sy;
	logic [PW-1:0] prod;
	logic          prod_neg;

	always_comb begin
		mul_x  = na_q;
		mul_sx = na_neg_q;
		mul_y  = db_q;
		mul_sy = db_neg_q;
		case (state_q)
			S_MUL1: begin
				if (cmd_q == rau_pkg::CMD_MUL) begin
					mul_y  = nb_q;
					mul_sy = nb_neg_q;
				end
			end
			S_MUL2: begin
				mul_x  = da_q;
				mul_sx = da_neg_q;
				mul_y  = nb_q;
				mul_sy = nb_neg_q;
			end
			S_MUL3: begin
				mul_x  = da_q;
				mul_sx = da_neg_q;
				if (cmd_q == rau_pkg::CMD_DIV) begin
					mul_y  = nb_q;
					mul_sy = nb_neg_q;
				end
			end
			default: begin
			end
		endcase
		prod     = PW'(mul_x) * PW'(mul_y);
		prod_neg = (mul_sx != mul_sy) && (prod != '0);
	end

	// Signed-magnitude add of the two cross products
	logic          t2_eff_neg;
	logic [PW-1:0] sum_mag;
	logic          sum_neg;

	always_comb begin
		t2_eff_neg = t2_neg_q ^ ((cmd_q == rau_pkg::CMD_SUB) && (t2_q != '0));
		if (rn_neg_q == t2_eff_neg) begin
			sum_mag = rn_q + t2_q;
			sum_neg = rn_neg_q;
		end else if (rn_q >= t2_q) begin
			sum_mag = rn_q - t2_q;
			sum_neg = rn_neg_q;
		end else begin
			sum_mag = t2_q - rn_q;
			sum_neg = t2_eff_neg;
		end
		if (sum_mag == '0) begin
			sum_neg = 1'b0;
		end
	end

	// Binary GCD step
	logic [PW-1:0] gcd_diff;
	logic          ga_gt;

	always_comb begin
		ga_gt    = ga_q > gb_q;
		gcd_diff = ga_gt ? (ga_q - gb_q) : (gb_q - ga_q);
	end

	// Restoring division step
	logic [PW:0]   rem_sh, rem_nx;
	logic          div_ge;
	logic [PW-1:0] quo_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[PW-1]};
		div_ge = rem_sh >= {1'b0, g_q};
		rem_nx = div_ge ? (rem_sh - {1'b0, g_q}) : rem_sh;
		quo_nx = {quo_q[PW-2:0], div_ge};
	end

	// Result formatting: sign, clamp, zero and error cases
	logic [64:0]        n_ext, n_sat;
	logic               res_neg, res_sat;
	rau_pkg::out_item_t res;

	always_comb begin
		res_neg = rn_neg_q != rd_neg_q;
		n_ext   = 65'(nmag_q);
		n_sat   = n_ext;
		res_sat = 1'b0;
		if (res_neg && (n_ext > rau_pkg::NEG_LIMIT)) begin
			n_sat   = rau_pkg::NEG_LIMIT;
			res_sat = 1'b1;
		end else if (!res_neg && (n_ext > rau_pkg::POS_LIMIT)) begin
			n_sat   = rau_pkg::POS_LIMIT;
			res_sat = 1'b1;
		end
		res.num_out = res_neg ? (~n_sat[63:0] + 64'd1) : n_sat[63:0];
		res.den_out = 63'(quo_q);
		res.status  = res_sat ? rau_pkg::ST_SAT : rau_pkg::ST_OK;
		if (err_q) begin
			res.num_out = '0;
			res.den_out = '0;
			res.status  = rau_pkg::ST_ZERO_DEN;
		end else if (zero_q) begin
			res.num_out = '0;
			res.den_out = 63'd1;
			res.status  = rau_pkg::ST_OK;
		end
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q    <= in_data.command;
						na_q     <= ma_n;
						da_q     <= ma_d;
						nb_q     <= mb_n;
						db_q     <= mb_d;
						na_neg_q <= xa_n[W-1];
						da_neg_q <= xa_d[W-1];
						nb_neg_q <= xb_n[W-1];
						db_neg_q <= xb_d[W-1];
						err_q    <= in_err;
						zero_q   <= 1'b0;
						state_q  <= in_err ? S_FIN : S_MUL1;
					end
				end
				S_MUL1: begin
					rn_q     <= prod;
					rn_neg_q <= prod_neg;
					state_q  <= ((cmd_q == rau_pkg::CMD_ADD) || (cmd_q == rau_pkg::CMD_SUB))
						? S_MUL2 : S_MUL3;
				end
				S_MUL2: begin
					t2_q     <= prod;
					t2_neg_q <= prod_neg;
					state_q  <= S_MUL3;
				end
				S_MUL3: begin
					rd_q     <= prod;
					rd_neg_q <= prod_neg;
					state_q  <= ((cmd_q == rau_pkg::CMD_ADD) || (cmd_q == rau_pkg::CMD_SUB))
						? S_ADD : S_ZCHK;
				end
				S_ADD: begin
					rn_q     <= sum_mag;
					rn_neg_q <= sum_neg;
					state_q  <= S_ZCHK;
				end
				S_ZCHK: begin
					ga_q <= rn_q;
					gb_q <= rd_q;
					k_q  <= '0;
					if (rn_q == '0) begin
						zero_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (ga_q == gb_q) begin
						g_q     <= ga_q << k_q;
						quo_q   <= rn_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIVN;
					end else if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						k_q  <= k_q + 1'b1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_gt) begin
						ga_q <= gcd_diff;
					end else begin
						gb_q <= gcd_diff;
					end
				end
				S_DIVN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PW - 1)) begin
						nmag_q  <= quo_nx;
						quo_q   <= rd_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIVD;
					end else begin
						quo_q <= quo_nx;
						rem_q <= rem_nx[PW-1:0];
					end
				end
				S_DIVD: begin
					quo_q <= quo_nx;
					rem_q <= rem_nx[PW-1:0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(PW - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_q       <= res;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

// ----- src/rau_chk.sv -----
// Checker: port-level properties of the rational arithmetic unit, bound to the top level.
`default_nettype none
module rau_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire rau_pkg::in_item_t  in_data,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire rau_pkg::out_item_t out_data
);

	// A held output item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output item changed while stalled");

	// Busy right after an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again without a busy cycle");

	// Error results are all zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == rau_pkg::ST_ZERO_DEN) |->
		(out_data.num_out == 64'sd0) && (out_data.den_out == 63'd0))
		else $error("zero-denominator item with nonzero fields");

	// Zero is always 0/1
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == rau_pkg::ST_OK) && (out_data.num_out == 64'sd0)
		|-> (out_data.den_out == 63'd1))
		else $error("zero result not normalized");

	// Good results carry a nonzero denominator
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != rau_pkg::ST_ZERO_DEN) |-> (out_data.den_out != 63'd0))
		else $error("zero denominator without error status");

endmodule

bind rational_arithmetic_unit_core rau_chk u_rau_chk (.*);
`default_nettype wire

// ----- verif/rational_arithmetic_unit_core_tb.sv -----
// Testbench for the rational arithmetic unit: random and directed fractions vs a predictor.
`default_nettype none
module rational_arithmetic_unit_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 700;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	rau_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	rau_pkg::out_item_t out_data;

	rau_pkg::in_item_t pending_items[$];
	rau_pkg::out_item_t expected_fracs[$];
	int errors;
	int idle_cycles;
	bit stim_done;
	bit in_acc;
	int in_gap;
	int out_gap;

	rational_arithmetic_unit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	// Magnitude and sign of a 32-bit two's complement operand
	function automatic void split_operand(input logic [31:0] v, output logic [63:0] mag,
			output bit neg);
		neg = v[31];
		mag = neg ? {32'd0, (~v) + 32'd1} : {32'd0, v};
		if (v == 32'h8000_0000) mag = 64'h8000_0000;
	endfunction

	function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// Reduced fraction expected for one item
	function automatic rau_pkg::out_item_t reduce_fraction(input rau_pkg::in_item_t it);
		rau_pkg::out_item_t r;
		logic [63:0] ma, mda, mb, mdb, p1, p2, rnm, rdm, g, nm, dm;
		bit sa, sda, sb, sdb, s1, s2, rns, neg;
		split_operand(it.num_a, ma, sa);
		split_operand(it.den_a, mda, sda);
		split_operand(it.num_b, mb, sb);
		split_operand(it.den_b, mdb, sdb);
		r.num_out = 0;
		r.den_out = 0;
		r.status = rau_pkg::ST_ZERO_DEN;
		if (mda == 0 || mdb == 0 || (it.command == rau_pkg::CMD_DIV && mb == 0)) return r;
		rdm = mda * mdb;
		neg = sda != sdb;
		case (it.command)
			rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
				p1 = ma * mdb;
				s1 = (sa != sdb) && p1 != 0;
				p2 = mda * mb;
				s2 = (sda != sb) && p2 != 0;
				if (it.command == rau_pkg::CMD_SUB && p2 != 0) s2 = !s2;
				if (s1 == s2) begin
					rnm = p1 + p2;
					rns = s1;
				end else if (p1 >= p2) begin
					rnm = p1 - p2;
					rns = s1;
				end else begin
					rnm = p2 - p1;
					rns = s2;
				end
			end
			rau_pkg::CMD_MUL: begin
				rnm = ma * mb;
				rns = sa != sb;
			end
			default: begin
				rnm = ma * mdb;
				rns = sa != sdb;
				rdm = mda * mb;
				neg = sda != sb;
			end
		endcase
		r.status = rau_pkg::ST_OK;
		if (rnm == 0) begin
			r.den_out = 1;
			return r;
		end
		neg = rns != neg;
		g = gcd64(rnm, rdm);
		nm = rnm / g;
		dm = rdm / g;
		if (neg) begin
			if (nm > 64'h8000_0000_0000_0000) begin
				nm = 64'h8000_0000_0000_0000;
				r.status = rau_pkg::ST_SAT;
			end
			r.num_out = (~nm) + 64'd1;
		end else begin
			if (nm > 64'h7FFF_FFFF_FFFF_FFFF) begin
				nm = 64'h7FFF_FFFF_FFFF_FFFF;
				r.status = rau_pkg::ST_SAT;
			end
			r.num_out = nm;
		end
		r.den_out = dm[62:0];
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(int'($urandom_range(0, 20)) - 10);
			3: return $urandom;
			default: return 32'(int'($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 9) < 5) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 300);
		return $urandom_range(1, 4);
	endfunction

	task automatic add_item(input rau_pkg::cmd_t c, input logic [31:0] na,
			input logic [31:0] da, input logic [31:0] nb, input logic [31:0] db);
		rau_pkg::in_item_t it;
		it.command = c;
		it.num_a = na;
		it.den_a = da;
		it.num_b = nb;
		it.den_b = db;
		pending_items.push_back(it);
	endtask

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Directed cases, then random items
	initial begin
		rau_pkg::cmd_t c;
		add_item(rau_pkg::CMD_ADD, 1, 2, 1, 3);
		add_item(rau_pkg::CMD_SUB, 1, 2, 1, 2);
		add_item(rau_pkg::CMD_MUL, -3, 4, 2, -9);
		add_item(rau_pkg::CMD_DIV, 5, 7, -10, 14);
		add_item(rau_pkg::CMD_ADD, 1, 0, 1, 1);
		add_item(rau_pkg::CMD_MUL, 1, 1, 1, 0);
		add_item(rau_pkg::CMD_DIV, 1, 1, 0, 5);
		add_item(rau_pkg::CMD_DIV, 0, 1, 3, 5);
		add_item(rau_pkg::CMD_MUL, 0, -7, 3, 5);
		add_item(rau_pkg::CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
		add_item(rau_pkg::CMD_MUL, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
		add_item(rau_pkg::CMD_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1);
		add_item(rau_pkg::CMD_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
		add_item(rau_pkg::CMD_SUB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF);
		add_item(rau_pkg::CMD_DIV, 32'h8000_0000, 1, 1, 32'h8000_0000);
		add_item(rau_pkg::CMD_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000);
		add_item(rau_pkg::CMD_ADD, -1, -1, -1, -1);
		add_item(rau_pkg::CMD_SUB, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h8000_0000);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			c = rau_pkg::cmd_t'($urandom_range(0, 3));
			add_item(c, rand_operand(), rand_operand(), rand_operand(), rand_operand());
		end
		stim_done = 1;
	end

	// Reset and input defaults
	initial begin
		errors = 0;
		idle_cycles = 0;
		in_gap = 0;
		out_gap = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// Driver: present items at the falling edge, hold until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				in_valid <= 0;
				in_gap <= rand_gap();
			end else if (!in_valid) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
				end else if (pending_items.size() > 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1;
				end
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1;
			end else begin
				out_stall <= 0;
				out_gap <= rand_gap();
			end
		end
	end

	// Monitor: predict on input acceptance, compare on output acceptance
	always @(posedge clk) begin
		rau_pkg::out_item_t exp_frac;
		bit took;
		took = 0;
		if (arst_n) begin
			in_acc <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				expected_fracs.push_back(reduce_fraction(in_data));
				took = 1;
			end
			if (out_valid && !out_stall) begin
				took = 1;
				if (expected_fracs.size() == 0) begin
					$display("%0t: unexpected result num=%0d den=%0d status=%0d", $time,
						out_data.num_out, out_data.den_out, out_data.status);
					errors <= errors + 1;
				end else begin
					exp_frac = expected_fracs.pop_front();
					if (out_data.num_out !== exp_frac.num_out ||
							out_data.den_out !== exp_frac.den_out ||
							out_data.status !== exp_frac.status) begin
						$display("%0t: mismatch expected %0d/%0d st=%0d actual %0d/%0d st=%0d",
							$time, exp_frac.num_out, exp_frac.den_out, exp_frac.status,
							out_data.num_out, out_data.den_out, out_data.status);
						errors <= errors + 1;
					end
				end
			end
			idle_cycles <= took ? 0 : idle_cycles + 1;
		end
	end

	// End of run and watchdog
	initial begin
		wait (arst_n);
		while (!(stim_done && pending_items.size() == 0 && !in_valid &&
				expected_fracs.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
		end else begin
			repeat (400) @(posedge clk);
			if (errors == 0 && expected_fracs.size() == 0) begin
				$display("RESULT: OK");
			end else begin
				$display("RESULT: ERROR");
			end
		end
		$finish;
	end
endmodule
`default_nettype wire
